### hdl/salru_pkg.sv
// Shared types and constants of the set-associative LRU tag unit.
package salru_pkg;

  localparam int unsigned OFFSET_W = 5;
  localparam int unsigned SETB_W   = 3;
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned WAY_OUT_W = 2;
  localparam int unsigned SET_OUT_W = 6;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST = 5'd6;
  localparam logic [SETB_W-1:0]   SET_BITS_RST    = 3'd6;

  // Register index, taken from paddr[2].
  localparam logic REG_OFFSET_BITS = 1'b0;
  localparam logic REG_SET_BITS    = 1'b1;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_bits;
    logic [SETB_W-1:0]   set_bits;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [SET_OUT_W-1:0] set_index;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

### hdl/salru_cfg.sv
// APB register file holding the offset and set bit counts.
module salru_cfg
  import salru_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_OFFSET_BITS: cfg_d.offset_bits = pwdata[OFFSET_W-1:0];
        REG_SET_BITS:    cfg_d.set_bits    = pwdata[SETB_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OFFSET_BITS: prdata = APB_DW'(cfg_q.offset_bits);
      REG_SET_BITS:    prdata = APB_DW'(cfg_q.set_bits);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_bits <= OFFSET_BITS_RST;
      cfg_q.set_bits    <= SET_BITS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/salru_store.sv
// Tag memory and valid/age memory, with the clearing sweep after reset.
module salru_store
  import salru_pkg::*;
#(
  parameter int unsigned NUM_SETS   = 64,
  parameter int unsigned NUM_WAYS   = 4,
  parameter int unsigned ADDR_WIDTH = 48,
  localparam int unsigned SET_IW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int unsigned TAG_ROW_W = NUM_WAYS * ADDR_WIDTH,
  localparam int unsigned META_W    = NUM_WAYS * (AGE_W + 1)
)(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [SET_IW-1:0]    rd_addr_i,
  output logic [TAG_ROW_W-1:0] rd_tag_o,
  output logic [META_W-1:0]    rd_meta_o,
  input  logic                 wr_en_i,
  input  logic                 wr_tag_en_i,
  input  logic [SET_IW-1:0]    wr_addr_i,
  input  logic [TAG_ROW_W-1:0] wr_tag_i,
  input  logic [META_W-1:0]    wr_meta_i,
  output logic                 clear_busy_o
);

  logic [TAG_ROW_W-1:0] tag_mem  [NUM_SETS];
  logic [META_W-1:0]    meta_mem [NUM_SETS];

  logic [SET_IW-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_busy_q, clr_busy_d;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == SET_IW'(NUM_SETS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Tags are never cleared: an invalid way's tag is never compared.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_tag_en_i) begin
      tag_mem[wr_addr_i] <= wr_tag_i;
    end
    if (rd_en_i) begin
      rd_tag_o <= tag_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      meta_mem[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      meta_mem[wr_addr_i] <= wr_meta_i;
    end
    if (rd_en_i) begin
      rd_meta_o <= meta_mem[rd_addr_i];
    end
  end

  assign clear_busy_o = clr_busy_q;

endmodule

### hdl/salru_ctrl.sv
// Address split, tag compare, LRU victim choice, age update and hit/miss counters.
module salru_ctrl
  import salru_pkg::*;
#(
  parameter int unsigned NUM_SETS   = 64,
  parameter int unsigned NUM_WAYS   = 4,
  parameter int unsigned ADDR_WIDTH = 48,
  localparam int unsigned SET_IW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int unsigned WAY_IW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1,
  localparam int unsigned TAG_ROW_W = NUM_WAYS * ADDR_WIDTH,
  localparam int unsigned META_W    = NUM_WAYS * (AGE_W + 1)
)(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  input  logic [ADDR_WIDTH-1:0] in_addr_i,
  output logic                  in_ready_o,
  input  logic                  out_free_i,
  input  logic                  clear_busy_i,
  output logic                  rd_en_o,
  output logic [SET_IW-1:0]     rd_addr_o,
  input  logic [TAG_ROW_W-1:0]  rd_tag_i,
  input  logic [META_W-1:0]     rd_meta_i,
  output logic                  wr_en_o,
  output logic                  wr_tag_en_o,
  output logic [SET_IW-1:0]     wr_addr_o,
  output logic [TAG_ROW_W-1:0]  wr_tag_o,
  output logic [META_W-1:0]     wr_meta_o,
  output logic                  res_valid_o,
  output result_t               res_o
);

  localparam int unsigned SB_LIM = $clog2(NUM_SETS + 1) - 1;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  state_e state_q, state_d;

  logic [SET_IW-1:0]     set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [CNT_W-1:0]      hit_cnt_q, hit_cnt_d, miss_cnt_q, miss_cnt_d;

  logic                  accept;
  logic [3:0]            sb_eff;
  logic [SET_IW-1:0]     set_mask;
  logic [ADDR_WIDTH-1:0] addr_shift;
  logic [5:0]            tag_shamt;
  logic [SET_IW-1:0]     set_in;
  logic [ADDR_WIDTH-1:0] tag_in;

  // Split of the incoming address; the set addresses the memories directly.
  always_comb begin
    sb_eff     = (4'(cfg_i.set_bits) > 4'(SB_LIM)) ? 4'(SB_LIM) : 4'(cfg_i.set_bits);
    set_mask   = ~({SET_IW{1'b1}} << sb_eff);
    addr_shift = in_addr_i >> cfg_i.offset_bits;
    set_in     = addr_shift[SET_IW-1:0] & set_mask;
    tag_shamt  = 6'(cfg_i.offset_bits) + 6'(sb_eff);
    tag_in     = in_addr_i >> tag_shamt;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (!clear_busy_i) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o  = 1'b0;
    wr_en_o     = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR:  ;
      ST_IDLE:   in_ready_o = out_free_i;
      ST_LOOKUP: begin
        wr_en_o     = 1'b1;
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept    = in_valid_i & in_ready_o;
  assign rd_en_o   = accept;
  assign rd_addr_o = set_in;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  logic [NUM_WAYS-1:0]   valid_w;
  logic [AGE_W-1:0]      age_w [NUM_WAYS];
  logic [NUM_WAYS-1:0]   hit_vec;
  logic                  hit;
  logic [WAY_IW-1:0]     hit_way, inv_way, old_way, way;
  logic                  any_inv;
  logic [AGE_W-1:0]      best_age;
  logic [NUM_WAYS-1:0]   new_valid;
  logic [AGE_W-1:0]      new_age;
  logic [31:0]           way_ext, set_ext;

  always_comb begin
    hit_vec  = '0;
    hit      = 1'b0;
    hit_way  = '0;
    any_inv  = 1'b0;
    inv_way  = '0;
    best_age = '0;
    old_way  = '0;
    wr_tag_o = rd_tag_i;
    wr_meta_o = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      valid_w[w] = rd_meta_i[w];
      age_w[w]   = rd_meta_i[NUM_WAYS + w*AGE_W +: AGE_W];
      hit_vec[w] = valid_w[w] && (rd_tag_i[w*ADDR_WIDTH +: ADDR_WIDTH] == tag_q);
    end
    // Lowest matching way wins, and the lowest invalid way is filled first.
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit     = 1'b1;
        hit_way = WAY_IW'(w);
      end
      if (!valid_w[w]) begin
        any_inv = 1'b1;
        inv_way = WAY_IW'(w);
      end
    end
    // Oldest way, ties kept by the lower way.
    best_age = age_w[0];
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (age_w[w] > best_age) begin
        best_age = age_w[w];
        old_way  = WAY_IW'(w);
      end
    end
    way = hit ? hit_way : (any_inv ? inv_way : old_way);

    new_valid = valid_w;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_IW'(w) == way) begin
        new_valid[w] = 1'b1;
        new_age      = '0;
        wr_tag_o[w*ADDR_WIDTH +: ADDR_WIDTH] = tag_q;
      end else begin
        new_age = (age_w[w] == AGE_MAX) ? AGE_MAX : age_w[w] + 1'b1;
      end
      wr_meta_o[NUM_WAYS + w*AGE_W +: AGE_W] = new_age;
    end
    wr_meta_o[NUM_WAYS-1:0] = new_valid;
  end

  assign wr_tag_en_o = ~hit;
  assign wr_addr_o   = set_q;

  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (state_q == ST_LOOKUP) begin
      if (hit) begin
        if (hit_cnt_q != CNT_MAX) hit_cnt_d = hit_cnt_q + 1'b1;
      end else begin
        if (miss_cnt_q != CNT_MAX) miss_cnt_d = miss_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
    end
  end

  always_comb begin
    way_ext         = 32'(way);
    set_ext         = 32'(set_q);
    res_o.hit       = hit;
    res_o.way       = way_ext[WAY_OUT_W-1:0];
    res_o.set_index = set_ext[SET_OUT_W-1:0];
    res_o.hit_count  = hit_cnt_d;
    res_o.miss_count = miss_cnt_d;
  end

`ifndef SYNTHESIS
  // The lookup state always hands back to idle on the next clock, which keeps a read of the
  // same set from overlapping its write.
  a_lookup_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |=> (state_q == ST_IDLE))
    else $error("lookup did not return to idle");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy_i |-> !in_ready_o)
    else $error("input accepted during the clearing sweep");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && !hit && miss_cnt_q != CNT_MAX)
      |=> (miss_cnt_q == $past(miss_cnt_q) + 1'b1) && $stable(hit_cnt_q))
    else $error("miss did not advance the miss counter alone");
`endif

endmodule

### hdl/set_assoc_cache_lru_tags_unit.sv
// Top level of the set-associative LRU cache tag unit.
//
// Each address beat is split into line offset, set index and tag using the
// offset_bits and set_bits registers, looked up in a NUM_SETS x NUM_WAYS tag
// store with LRU ages, and answered by one result beat: hit flag in tuser,
// way, set and the saturating hit and miss counts in tdata. An item reads the
// set from the synchronous tag and age memories, then compares, picks the
// way and writes the set back; a new address is taken only once the last is
// written back and while the result register drains. After reset a sweep
// clears the valid bits and ages of all NUM_SETS sets, one set a cycle,
// before the first address is taken; register writes are accepted meanwhile.
module set_assoc_cache_lru_tags_unit
  import salru_pkg::*;
#(
  parameter int unsigned NUM_SETS   = 64,
  parameter int unsigned NUM_WAYS   = 4,
  parameter int unsigned ADDR_WIDTH = 48,
  localparam int unsigned IN_TDATA_W = ((ADDR_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = WAY_OUT_W + SET_OUT_W + 2 * CNT_W
)(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  // Address stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // address, zero padded
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // way, set_index, hit_count, miss_count
  output logic                   m_axis_tuser   // hit
);

  localparam int unsigned SET_IW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned TAG_ROW_W = NUM_WAYS * ADDR_WIDTH;
  localparam int unsigned META_W    = NUM_WAYS * (AGE_W + 1);

  cfg_t    cfg;
  result_t res;
  result_t out_q;
  logic    res_valid;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  logic    clear_busy;

  logic                 rd_en, wr_en, wr_tag_en;
  logic [SET_IW-1:0]    rd_addr, wr_addr;
  logic [TAG_ROW_W-1:0] rd_tag, wr_tag;
  logic [META_W-1:0]    rd_meta, wr_meta;

  salru_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  salru_store #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_tag_o     (rd_tag),
    .rd_meta_o    (rd_meta),
    .wr_en_i      (wr_en),
    .wr_tag_en_i  (wr_tag_en),
    .wr_addr_i    (wr_addr),
    .wr_tag_i     (wr_tag),
    .wr_meta_i    (wr_meta),
    .clear_busy_o (clear_busy)
  );

  salru_ctrl #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_addr_i    (s_axis_tdata[ADDR_WIDTH-1:0]),
    .in_ready_o   (s_axis_tready),
    .out_free_i   (out_free),
    .clear_busy_i (clear_busy),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_tag_i     (rd_tag),
    .rd_meta_i    (rd_meta),
    .wr_en_o      (wr_en),
    .wr_tag_en_o  (wr_tag_en),
    .wr_addr_o    (wr_addr),
    .wr_tag_o     (wr_tag),
    .wr_meta_o    (wr_meta),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // The result register is free by the time the lookup after an accept ends.
  assign out_free = ~out_valid_q | m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.hit;
  assign m_axis_tdata  = {out_q.miss_count, out_q.hit_count, out_q.set_index, out_q.way};

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten before its beat was taken");
`endif

endmodule
